FILE: sv/octree_code_to_position_assert.svh
// Assertion macros used by the checker file.
`ifndef OCTREE_CODE_TO_POSITION_ASSERT_SVH
`define OCTREE_CODE_TO_POSITION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define OC2P_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oc2p: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define OC2P_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oc2p: next-cycle check failed");

`endif

FILE: sv/oc2p_pkg.sv
package oc2p_pkg;

  localparam int FracBits    = 24;
  localparam int MaxDepthDef = 24;

  // length byte codes
  localparam logic [7:0] LenExt  = 8'hFF;
  localparam logic [7:0] LenNone = 8'h00;

  // walker state going into one data byte
  typedef struct packed {
    logic [7:0] depth;
    logic [7:0] done;
    logic [1:0] cbits;
    logic [1:0] ccnt;
  } walk_st_t;

  // walker state after one data byte
  typedef struct packed {
    logic [7:0] done;
    logic [1:0] cbits;
    logic [1:0] ccnt;
    logic       fin;
  } walk_res_t;

endpackage

FILE: sv/oc2p_walk.sv
module oc2p_walk #(
  parameter int MAX_DEPTH = oc2p_pkg::MaxDepthDef
) (
  input  oc2p_pkg::walk_st_t                 st,
  input  logic [7:0]                         code_byte,
  input  logic [oc2p_pkg::FracBits-1:0]      acc_x,
  input  logic [oc2p_pkg::FracBits-1:0]      acc_y,
  input  logic [oc2p_pkg::FracBits-1:0]      acc_z,
  output oc2p_pkg::walk_res_t                res,
  output logic [oc2p_pkg::FracBits-1:0]      nacc_x,
  output logic [oc2p_pkg::FracBits-1:0]      nacc_y,
  output logic [oc2p_pkg::FracBits-1:0]      nacc_z
);

  localparam logic [7:0] MaxD = 8'(MAX_DEPTH);
  localparam logic [oc2p_pkg::FracBits-1:0] TopBit = {1'b1, {(oc2p_pkg::FracBits-1){1'b0}}};

  logic [9:0] val;
  logic [3:0] nbits;
  logic [2:0] take;
  logic [8:0] lvl [3];
  logic [2:0] sec [3];
  logic [oc2p_pkg::FracBits-1:0] wt [3];
  logic [1:0] n;
  logic [3:0] nafter;
  logic [1:0] rem;
  logic [1:0] cmask;
  logic [7:0] done_nxt;

  assign val   = {st.cbits, code_byte};
  assign nbits = 4'(st.ccnt) + 4'd8;

  // at most three sections fit in carry plus one byte
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lvl[k]  = {1'b0, st.done} + 9'(k);
      take[k] = (nbits >= 4'(3 * (k + 1))) && (lvl[k] < {1'b0, st.depth});
      sec[k]  = 3'(val >> (nbits - 4'(3 * (k + 1))));
      // each level owns one bit, so setting it equals adding the weight
      wt[k]   = (take[k] && (lvl[k][7:0] < MaxD)) ? (TopBit >> lvl[k][7:0]) : '0;
    end
  end

  assign nacc_x = acc_x | (sec[0][2] ? wt[0] : '0) | (sec[1][2] ? wt[1] : '0)
                        | (sec[2][2] ? wt[2] : '0);
  assign nacc_y = acc_y | (sec[0][1] ? wt[0] : '0) | (sec[1][1] ? wt[1] : '0)
                        | (sec[2][1] ? wt[2] : '0);
  assign nacc_z = acc_z | (sec[0][0] ? wt[0] : '0) | (sec[1][0] ? wt[1] : '0)
                        | (sec[2][0] ? wt[2] : '0);

  assign n        = 2'(take[0]) + 2'(take[1]) + 2'(take[2]);
  assign nafter   = nbits - ({1'b0, n, 1'b0} + {2'b00, n});
  assign rem      = nafter[1:0];
  assign cmask    = 2'((3'b001 << rem) - 3'b001);
  assign done_nxt = st.done + 8'(n);

  assign res.done  = done_nxt;
  assign res.ccnt  = rem;
  assign res.cbits = val[1:0] & cmask;
  assign res.fin   = (done_nxt >= st.depth);

endmodule

FILE: sv/octree_code_to_position.sv
// channel  | ports                                     | dir | accepted when
// ---------+-------------------------------------------+-----+---------------------
// input    | in_valid, in_ready, in_code_byte          | in  | in_valid & in_ready
// result   | out_valid, out_ready, out_pos_x/y/z,      | out | out_valid & out_ready
//          | out_cell_scale, out_code_depth,           |     |
//          | out_truncated, out_length_error          |     |
//
// One code byte per cycle while no result waits unaccepted, set by the byte register feeding the section walker.
// A result is valid once the byte that ends a code has passed the byte register and the result register.
// Synchronous active-low reset; afterwards the next byte is a length byte.
// While a result waits unaccepted, the byte register can still take at most one more
// byte, after which in_ready stays low until the result moves on.
module octree_code_to_position #(
  parameter int MAX_DEPTH = oc2p_pkg::MaxDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_code_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_pos_x,
  output logic [23:0] out_pos_y,
  output logic [23:0] out_pos_z,
  output logic [24:0] out_cell_scale,
  output logic [7:0]  out_code_depth,
  output logic        out_truncated,
  output logic        out_length_error
);

  localparam logic [7:0]  MaxD  = 8'(MAX_DEPTH);
  localparam logic [24:0] Unity = 25'h1000000;

  // byte register
  logic       byte_vld_r;
  logic [7:0] byte_r;

  // decoder state
  logic        expect_len_r, expect_len_nxt;
  logic [7:0]  depth_r, depth_nxt;
  logic [7:0]  done_r, done_nxt;
  logic [6:0]  bleft_r, bleft_nxt;
  logic [1:0]  cbits_r, cbits_nxt;
  logic [1:0]  ccnt_r, ccnt_nxt;
  logic [23:0] acc_x_r, acc_x_nxt;
  logic [23:0] acc_y_r, acc_y_nxt;
  logic [23:0] acc_z_r, acc_z_nxt;

  // result register
  logic        out_valid_r;
  logic [23:0] pos_x_r, pos_y_r, pos_z_r;
  logic [24:0] scale_r;
  logic [7:0]  depth_o_r;
  logic        trunc_r, lerr_r;

  logic adv, go, emit;
  logic [23:0] r_x, r_y, r_z;
  logic [7:0]  r_depth;
  logic        r_lerr;
  logic [24:0] r_scale;
  logic        r_trunc;
  logic [9:0]  len3;
  logic [6:0]  bleft_dec;

  oc2p_pkg::walk_st_t  wst;
  oc2p_pkg::walk_res_t wres;
  logic [23:0] w_x, w_y, w_z;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !byte_vld_r || adv;
  assign go       = byte_vld_r && adv;

  assign wst.depth = depth_r;
  assign wst.done  = done_r;
  assign wst.cbits = cbits_r;
  assign wst.ccnt  = ccnt_r;

  oc2p_walk #(.MAX_DEPTH(MAX_DEPTH)) u_walk (
    .st(wst), .code_byte(byte_r),
    .acc_x(acc_x_r), .acc_y(acc_y_r), .acc_z(acc_z_r),
    .res(wres), .nacc_x(w_x), .nacc_y(w_y), .nacc_z(w_z)
  );

  // data bytes = ceil(3 * depth / 8)
  assign len3      = {1'b0, byte_r, 1'b0} + {2'b00, byte_r} + 10'd7;
  assign bleft_dec = bleft_r - 7'd1;

  always_comb begin
    expect_len_nxt = expect_len_r;
    depth_nxt      = depth_r;
    done_nxt       = done_r;
    bleft_nxt      = bleft_r;
    cbits_nxt      = cbits_r;
    ccnt_nxt       = ccnt_r;
    acc_x_nxt      = acc_x_r;
    acc_y_nxt      = acc_y_r;
    acc_z_nxt      = acc_z_r;
    emit           = 1'b0;
    r_x            = '0;
    r_y            = '0;
    r_z            = '0;
    r_depth        = '0;
    r_lerr         = 1'b0;
    if (expect_len_r) begin
      if (byte_r == oc2p_pkg::LenExt) begin
        emit   = 1'b1;
        r_lerr = 1'b1;
      end else if (byte_r == oc2p_pkg::LenNone) begin
        emit = 1'b1;
      end else begin
        depth_nxt      = byte_r;
        done_nxt       = '0;
        bleft_nxt      = len3[9:3];
        cbits_nxt      = '0;
        ccnt_nxt       = '0;
        acc_x_nxt      = '0;
        acc_y_nxt      = '0;
        acc_z_nxt      = '0;
        expect_len_nxt = 1'b0;
      end
    end else begin
      done_nxt  = wres.done;
      cbits_nxt = wres.cbits;
      ccnt_nxt  = wres.ccnt;
      acc_x_nxt = w_x;
      acc_y_nxt = w_y;
      acc_z_nxt = w_z;
      bleft_nxt = bleft_dec;
      r_x       = w_x;
      r_y       = w_y;
      r_z       = w_z;
      r_depth   = depth_r;
      if (bleft_dec == 7'd0 || wres.fin) begin
        emit           = 1'b1;
        expect_len_nxt = 1'b1;
        bleft_nxt      = '0;
        cbits_nxt      = '0;
        ccnt_nxt       = '0;
      end
    end
  end

  // scale is zero past the depth limit; error results carry no depth
  assign r_trunc = !r_lerr && (r_depth > MaxD);
  assign r_scale = (!r_lerr && (r_depth <= MaxD)) ? (Unity >> r_depth) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      expect_len_r <= 1'b1;
      depth_r      <= '0;
      done_r       <= '0;
      bleft_r      <= '0;
      cbits_r      <= '0;
      ccnt_r       <= '0;
      acc_x_r      <= '0;
      acc_y_r      <= '0;
      acc_z_r      <= '0;
    end else begin
      if (in_ready) begin
        byte_vld_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= go && emit;
      end
      if (go) begin
        expect_len_r <= expect_len_nxt;
        depth_r      <= depth_nxt;
        done_r       <= done_nxt;
        bleft_r      <= bleft_nxt;
        cbits_r      <= cbits_nxt;
        ccnt_r       <= ccnt_nxt;
        acc_x_r      <= acc_x_nxt;
        acc_y_r      <= acc_y_nxt;
        acc_z_r      <= acc_z_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_code_byte;
    end
    if (go && emit) begin
      pos_x_r   <= r_x;
      pos_y_r   <= r_y;
      pos_z_r   <= r_z;
      scale_r   <= r_scale;
      depth_o_r <= r_depth;
      trunc_r   <= r_trunc;
      lerr_r    <= r_lerr;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = pos_x_r;
  assign out_pos_y        = pos_y_r;
  assign out_pos_z        = pos_z_r;
  assign out_cell_scale   = scale_r;
  assign out_code_depth   = depth_o_r;
  assign out_truncated    = trunc_r;
  assign out_length_error = lerr_r;

endmodule

FILE: sv/oc2p_chk.sv
`include "octree_code_to_position_assert.svh"

module oc2p_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_pos_x,
  input logic [23:0] out_pos_y,
  input logic [23:0] out_pos_z,
  input logic [24:0] out_cell_scale,
  input logic [7:0]  out_code_depth,
  input logic        out_truncated,
  input logic        out_length_error
);

  // a stalled result item stays valid and keeps its x position, scale and depth
  `OC2P_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_pos_x) && $stable(out_cell_scale) && $stable(out_code_depth))

  // error results carry nothing else
  `OC2P_ASSERT_IMP(a_err_clean, out_valid && out_length_error,
    out_code_depth == 8'd0 && out_cell_scale == 25'd0 && !out_truncated &&
    out_pos_x == 24'd0 && out_pos_y == 24'd0 && out_pos_z == 24'd0)

  // scale is a single power of two or zero
  `OC2P_ASSERT_IMP(a_scale_pow2, out_valid, $onehot0(out_cell_scale))

  // dropped sections leave no cell size
  `OC2P_ASSERT_IMP(a_trunc_scale, out_valid && out_truncated, out_cell_scale == 25'd0)

  // empty code is the whole cube at the origin
  `OC2P_ASSERT_IMP(a_empty_code, out_valid && !out_length_error && out_code_depth == 8'd0,
    out_cell_scale == 25'h1000000 && out_pos_x == 24'd0 && out_pos_y == 24'd0 &&
    out_pos_z == 24'd0)

endmodule

bind octree_code_to_position oc2p_chk u_oc2p_chk (.*);
